[rtl/jsu_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and character constants for the JSON string unescaper.
// No dependencies; used by jsu_step, jsu_out_fifo, the top level and the checker.
package jsu_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA   = 3'd0,
    ST_QUOTE  = 3'd1,
    ST_SRCEND = 3'd2,
    ST_TRUNC  = 3'd3,
    ST_NOTSTR = 3'd4
  } status_e;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSLSH = 8'h5C;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;

  localparam logic [15:0] MaxLenReset = 16'd255;

  // Result queue depth; room for two words is needed to take an input word.
  localparam int unsigned QDepth = 4;

  typedef struct packed {
    status_e    status;
    logic       is_end;
    logic [7:0] out_byte;
  } result_t;

  // Everything one input word produces.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } step_t;

  function automatic result_t mk_data(input logic [7:0] b);
    result_t r;
    r.status   = ST_DATA;
    r.is_end   = 1'b0;
    r.out_byte = b;
    return r;
  endfunction

  function automatic result_t mk_term(input status_e st);
    result_t r;
    r.status   = st;
    r.is_end   = 1'b1;
    r.out_byte = CH_NUL;
    return r;
  endfunction

endpackage

[rtl/json_quoted_string_unescaper.sv]
`timescale 1ns / 1ps
// Top level of the JSON quoted-string unescaper: parser state, cap register,
// decode (jsu_step) and result queue (jsu_out_fifo). Uses jsu_pkg.
//
//   channel   direction  tdata          tuser         tlast
//   s_axis    in         [7:0] in_byte  [0] first     -
//   m_axis    out        [7:0] out_byte [2:0] status  is_end
//   cfg       in         [15:0] max_length (write on cfg_we_i)
//
// One source word is taken per cycle while s_axis_tready is high; its results land
// in the queue on the same edge and show at m_axis once earlier entries have left.
// A word that yields two results (escape passed through, escape then end)
// fills two queue entries; s_axis_tready drops while the four-entry
// queue has room for fewer than two words.
// Reset clears parser state and the queue and sets max_length to 255.
module json_quoted_string_unescaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // is_end
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  jsu_pkg::phase_e  phase_q, phase_d;
  logic [15:0]      count_q, count_d;
  logic [15:0]      max_len_q;
  jsu_pkg::step_t   step;
  jsu_pkg::result_t head;
  logic             in_accept;
  logic             room;
  logic [1:0]       push_n;

  assign s_axis_tready = room;
  assign in_accept     = s_axis_tvalid && room;
  assign push_n        = in_accept ? step.n : 2'd0;

  jsu_step u_step (
    .phase_i   (phase_q),
    .count_i   (count_q),
    .max_len_i (max_len_q),
    .in_byte_i (s_axis_tdata),
    .first_i   (s_axis_tuser),
    .step_o    (step),
    .phase_o   (phase_d),
    .count_o   (count_d)
  );

  jsu_out_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (step.r0),
    .push1_i  (step.r1),
    .pop_i    (m_axis_tvalid && m_axis_tready),
    .head_o   (head),
    .valid_o  (m_axis_tvalid),
    .room_o   (room)
  );

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tlast = head.is_end;
  assign m_axis_tuser = head.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= jsu_pkg::PH_IDLE;
      count_q   <= '0;
      max_len_q <= jsu_pkg::MaxLenReset;
    end else begin
      if (in_accept) begin
        phase_q <= phase_d;
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

endmodule

[rtl/jsu_step.sv]
`timescale 1ns / 1ps
// Per-word decode: results and next parser state for one source byte.
// Pure combinational; uses jsu_pkg.
module jsu_step (
  input  jsu_pkg::phase_e phase_i,
  input  logic [15:0]     count_i,
  input  logic [15:0]     max_len_i,
  input  logic [7:0]      in_byte_i,
  input  logic            first_i,
  output jsu_pkg::step_t  step_o,
  output jsu_pkg::phase_e phase_o,
  output logic [15:0]     count_o
);

  logic [15:0] count_inc;
  logic        at_cap;
  logic        at_cap_inc;
  logic        drop_ctrl;
  logic        esc_known;
  logic [7:0]  esc_byte;

  assign count_inc  = count_i + 16'd1;
  assign at_cap     = count_i >= max_len_i;
  assign at_cap_inc = count_inc >= max_len_i;
  assign drop_ctrl  = (in_byte_i < jsu_pkg::CH_SPACE) &&
                      !(in_byte_i inside {jsu_pkg::CH_BS, jsu_pkg::CH_TAB, jsu_pkg::CH_LF,
                                          jsu_pkg::CH_FF, jsu_pkg::CH_CR});

  always_comb begin
    esc_known = 1'b1;
    esc_byte  = in_byte_i;
    case (in_byte_i)
      jsu_pkg::CH_QUOTE: esc_byte = jsu_pkg::CH_QUOTE;
      jsu_pkg::CH_BSLSH: esc_byte = jsu_pkg::CH_BSLSH;
      jsu_pkg::CH_SLASH: esc_byte = jsu_pkg::CH_SLASH;
      jsu_pkg::CH_LC_B:  esc_byte = jsu_pkg::CH_BS;
      jsu_pkg::CH_LC_F:  esc_byte = jsu_pkg::CH_FF;
      jsu_pkg::CH_LC_N:  esc_byte = jsu_pkg::CH_LF;
      jsu_pkg::CH_LC_R:  esc_byte = jsu_pkg::CH_CR;
      jsu_pkg::CH_LC_T:  esc_byte = jsu_pkg::CH_TAB;
      default:           esc_known = 1'b0;
    endcase
  end

  always_comb begin
    step_o.n  = 2'd0;
    step_o.r0 = jsu_pkg::mk_data(in_byte_i);
    step_o.r1 = jsu_pkg::mk_data(in_byte_i);
    phase_o   = phase_i;
    count_o   = count_i;
    if (first_i) begin
      count_o = 16'd0;
      if (in_byte_i == jsu_pkg::CH_QUOTE) begin
        phase_o = jsu_pkg::PH_STR;
      end else begin
        step_o.n  = 2'd1;
        step_o.r0 = jsu_pkg::mk_term(jsu_pkg::ST_NOTSTR);
        phase_o   = jsu_pkg::PH_IDLE;
      end
    end else begin
      case (phase_i)
        jsu_pkg::PH_STR: begin
          if (in_byte_i == jsu_pkg::CH_QUOTE) begin
            step_o.n  = 2'd1;
            step_o.r0 = jsu_pkg::mk_term(jsu_pkg::ST_QUOTE);
            phase_o   = jsu_pkg::PH_IDLE;
          end else if (in_byte_i == jsu_pkg::CH_NUL) begin
            step_o.n  = 2'd1;
            step_o.r0 = jsu_pkg::mk_term(jsu_pkg::ST_SRCEND);
            phase_o   = jsu_pkg::PH_IDLE;
          end else if (at_cap) begin
            step_o.n  = 2'd1;
            step_o.r0 = jsu_pkg::mk_term(jsu_pkg::ST_TRUNC);
            phase_o   = jsu_pkg::PH_IDLE;
          end else if (drop_ctrl) begin
            step_o.n = 2'd0;
          end else if (in_byte_i == jsu_pkg::CH_BSLSH) begin
            phase_o = jsu_pkg::PH_ESC;
          end else begin
            step_o.n = 2'd1;
            count_o  = count_inc;
          end
        end
        jsu_pkg::PH_ESC: begin
          step_o.r0 = jsu_pkg::mk_data(jsu_pkg::CH_BSLSH);
          count_o   = count_inc;
          if (esc_known) begin
            step_o.n  = 2'd1;
            step_o.r0 = jsu_pkg::mk_data(esc_byte);
            phase_o   = jsu_pkg::PH_STR;
          end else if (in_byte_i == jsu_pkg::CH_NUL) begin
            // backslash then end of source: keep the backslash, then close
            step_o.n  = 2'd2;
            step_o.r1 = jsu_pkg::mk_term(jsu_pkg::ST_SRCEND);
            phase_o   = jsu_pkg::PH_IDLE;
          end else if (at_cap_inc) begin
            step_o.n  = 2'd2;
            step_o.r1 = jsu_pkg::mk_term(jsu_pkg::ST_TRUNC);
            phase_o   = jsu_pkg::PH_IDLE;
          end else begin
            step_o.n  = 2'd2;
            count_o   = count_i + 16'd2;
            phase_o   = jsu_pkg::PH_STR;
          end
        end
        default: begin
          step_o.n = 2'd0;
        end
      endcase
    end
  end

endmodule

[rtl/jsu_out_fifo.sv]
`timescale 1ns / 1ps
// Result queue: takes up to two result words per cycle, hands out one.
// Uses jsu_pkg for the result type and depth.
module jsu_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       push_n_i,
  input  jsu_pkg::result_t push0_i,
  input  jsu_pkg::result_t push1_i,
  input  logic             pop_i,
  output jsu_pkg::result_t head_o,
  output logic             valid_o,
  output logic             room_o
);

  localparam int unsigned PtrW = $clog2(jsu_pkg::QDepth);
  localparam int unsigned CntW = $clog2(jsu_pkg::QDepth + 1);

  jsu_pkg::result_t slot_q [jsu_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  wr_ptr_nxt;

  assign wr_ptr_nxt = wr_ptr_q + PtrW'(1);
  assign valid_o    = cnt_q != '0;
  assign room_o     = cnt_q <= CntW'(jsu_pkg::QDepth - 2);
  assign head_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_n_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + CntW'(push_n_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      slot_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      slot_q[wr_ptr_nxt] <= push1_i;
    end
  end

endmodule

[rtl/jsu_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for json_quoted_string_unescaper, bound to the top level.
// Uses jsu_pkg for status codes and the quote character.
module jsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);

  // hold the result word while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("result word changed under stall");

  // terminator words carry a zero byte and a nonzero status; data words status 0
  a_term_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tlast == (m_axis_tuser != 3'd0)) &&
      (!m_axis_tlast || m_axis_tdata == 8'd0) &&
      (m_axis_tuser <= 3'(jsu_pkg::ST_NOTSTR)))
    else $error("malformed result word");

  // an empty queue always has room
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result queue");

  // a start word that is not a quote, taken with the queue empty, closes at once as not-a-string
  a_not_str: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser &&
    (s_axis_tdata != jsu_pkg::CH_QUOTE) && !m_axis_tvalid |=>
      m_axis_tvalid && m_axis_tlast && (m_axis_tuser == 3'(jsu_pkg::ST_NOTSTR)))
    else $error("missing not-a-string terminator");

endmodule

bind json_quoted_string_unescaper jsu_checker u_jsu_checker (.*);
